/* sv/rbsf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the rectangle border/shadow fill engine.
// No dependencies; the core and the top level refer to it by scoped names.
package rbsf_pkg;

    // Largest edge coordinate; edges above it are saturated to it.
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Fill modes as written to the fill_mode register.
    typedef enum logic [2:0] {
        MODE_FILL          = 3'd0,
        MODE_BORDER        = 3'd1,
        MODE_BORDER_SHADOW = 3'd2,
        MODE_SET_ALPHA     = 3'd3,
        MODE_SET_RGB       = 3'd4
    } t_fill_mode;

    // Register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_RECT_LEFT       = 3'd0;
    localparam logic [2:0] REG_RECT_TOP        = 3'd1;
    localparam logic [2:0] REG_RECT_RIGHT      = 3'd2;
    localparam logic [2:0] REG_RECT_BOTTOM     = 3'd3;
    localparam logic [2:0] REG_FILL_MODE       = 3'd4;
    localparam logic [2:0] REG_FILL_COLOR      = 3'd5;
    localparam logic [2:0] REG_BORDER_SIZE     = 3'd6;
    localparam logic [2:0] REG_SHADOW_STRENGTH = 3'd7;

    typedef struct packed {
        logic [12:0] rect_left;
        logic [12:0] rect_top;
        logic [12:0] rect_right;
        logic [12:0] rect_bottom;
        logic [2:0]  fill_mode;
        logic [31:0] fill_color;
        logic [12:0] border_size;
        logic [7:0]  shadow_strength;
    } t_cfg;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        modified;
    } t_pix_out;

endpackage

/* sv/rbsf_pixel_core.sv */
`timescale 1ns / 1ps
// Per-pixel datapath: rectangle hit test, border band, shadow count and shading.
// Depends on rbsf_pkg for the configuration, payload types and mode codes.
module rbsf_pixel_core (
    input  rbsf_pkg::t_cfg     i_cfg,
    input  rbsf_pkg::t_pix_in  i_pix,
    output rbsf_pkg::t_pix_out o_pix
);

    // Subtract k * strength from every channel, saturating at zero.
    function automatic logic [31:0] shade(input logic [31:0] px,
                                          input logic [2:0]  k,
                                          input logic [7:0]  s);
        logic [10:0] amount;
        logic [31:0] res;
        amount = 11'(k * s);
        for (int i = 0; i < 4; i++) begin
            if ({3'b000, px[8*i +: 8]} > amount) begin
                res[8*i +: 8] = px[8*i +: 8] - amount[7:0];
            end else begin
                res[8*i +: 8] = 8'd0;
            end
        end
        return res;
    endfunction

    logic [12:0] l, t, r, b;
    logic [12:0] x, y;
    logic        in_rect;
    logic [13:0] u, v, w, h, bs;
    logic        band;
    logic [2:0]  k_edge, k_ring;
    logic        s0, s1, s2, s3;

    always_comb begin
        l = (i_cfg.rect_left   > rbsf_pkg::MAX_DIM) ? rbsf_pkg::MAX_DIM : i_cfg.rect_left;
        t = (i_cfg.rect_top    > rbsf_pkg::MAX_DIM) ? rbsf_pkg::MAX_DIM : i_cfg.rect_top;
        r = (i_cfg.rect_right  > rbsf_pkg::MAX_DIM) ? rbsf_pkg::MAX_DIM : i_cfg.rect_right;
        b = (i_cfg.rect_bottom > rbsf_pkg::MAX_DIM) ? rbsf_pkg::MAX_DIM : i_cfg.rect_bottom;
        x = {1'b0, i_pix.pixel_x};
        y = {1'b0, i_pix.pixel_y};
        in_rect = (x >= l) && (x < r) && (y >= t) && (y < b);

        // Relative coordinates and size; meaningful only when inside.
        u  = {1'b0, 13'(x - l)};
        v  = {1'b0, 13'(y - t)};
        w  = {1'b0, 13'(r - l)};
        h  = {1'b0, 13'(b - t)};
        bs = {1'b0, i_cfg.border_size};

        band = (u < bs) || (v < bs) || (u + bs >= w) || (v + bs >= h);

        k_edge = 3'((v == 14'd0)) + 3'((u == 14'd0))
               + 3'((v + 14'd1 == h)) + 3'((u + 14'd1 == w));

        // Inner ring segments: top row, left column, bottom row, right column.
        s0 = (v + 14'd1 == bs) && (u + 14'd1 >= bs) && (u + bs < w);
        s1 = (u + 14'd1 == bs) && (v >= bs) && (v + bs < h);
        s2 = (v + bs == h) && (u + 14'd1 >= bs) && (u + bs <= w);
        s3 = (u + bs == w) && (v + 14'd1 >= bs) && (v + bs < h);
        k_ring = 3'(s0) + 3'(s1) + 3'(s2) + 3'(s3);

        o_pix.pixel_out = i_pix.pixel_in;
        o_pix.modified  = 1'b0;
        if (in_rect) begin
            case (i_cfg.fill_mode)
                rbsf_pkg::MODE_FILL: begin
                    o_pix.pixel_out = shade(i_cfg.fill_color, k_edge, i_cfg.shadow_strength);
                    o_pix.modified  = 1'b1;
                end
                rbsf_pkg::MODE_BORDER: begin
                    if (bs != 14'd0 && band) begin
                        o_pix.pixel_out = i_cfg.fill_color;
                        o_pix.modified  = 1'b1;
                    end
                end
                rbsf_pkg::MODE_BORDER_SHADOW: begin
                    if (bs != 14'd0 && band) begin
                        o_pix.pixel_out = shade(i_cfg.fill_color, k_ring,
                                                i_cfg.shadow_strength);
                        o_pix.modified  = 1'b1;
                    end
                end
                rbsf_pkg::MODE_SET_ALPHA: begin
                    o_pix.pixel_out = {i_cfg.fill_color[31:24], i_pix.pixel_in[23:0]};
                    o_pix.modified  = 1'b1;
                end
                rbsf_pkg::MODE_SET_RGB: begin
                    o_pix.pixel_out = {i_pix.pixel_in[31:24], i_cfg.fill_color[23:0]};
                    o_pix.modified  = 1'b1;
                end
                default: begin
                    // unused modes pass the pixel through
                    o_pix.modified = 1'b0;
                end
            endcase
        end
    end

endmodule

/* sv/rect_border_shadow_fill.sv */
`timescale 1ns / 1ps
// Top level of the rectangle border/shadow fill engine: APB register file,
// input register, pixel core and result register. Depends on rbsf_pkg, rbsf_pixel_core.
//
// Usage:
//   Pixels enter on the input channel (i_in_valid / o_in_ready, payload i_in_data
//   with pixel_x, pixel_y, pixel_in) and leave on the output channel
//   (o_out_valid / i_out_ready, payload o_out_data with pixel_out, modified).
//   A transfer happens at a rising edge where valid and ready are both high.
//   Throughput: one pixel per cycle while the receiver keeps i_out_ready high;
//   a pixel passes from the input register through the combinational pixel core
//   into the output register, from which it leaves on the output channel.
//   When the receiver stalls, the output register holds its result and the input
//   register may still take one more pixel; ready drops only when both are full.
//   Registers are written over APB (access-phase write, pready tied high) and should
//   be changed only while no pixel is in flight. Reset (i_rst_n low, synchronous)
//   empties the pipeline and restores the registers: all zero, border_size = 1.
module rect_border_shadow_fill (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rbsf_pkg::t_pix_in     i_in_data,
    // pixel output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rbsf_pkg::t_pix_out    o_out_data
);

    rbsf_pkg::t_cfg     r_cfg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic               r_s1_valid, n_s1_valid;
    rbsf_pkg::t_pix_in  r_s1_data;
    logic               r_out_valid, n_out_valid;
    rbsf_pkg::t_pix_out r_out_data;
    rbsf_pkg::t_pix_out core_out;
    logic               s1_advance;

    // ---------------------------------------------------------------- registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left       <= 13'd0;
            r_cfg.rect_top        <= 13'd0;
            r_cfg.rect_right      <= 13'd0;
            r_cfg.rect_bottom     <= 13'd0;
            r_cfg.fill_mode       <= 3'd0;
            r_cfg.fill_color      <= 32'd0;
            r_cfg.border_size     <= 13'd1;
            r_cfg.shadow_strength <= 8'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rbsf_pkg::REG_RECT_LEFT:       r_cfg.rect_left       <= pwdata[12:0];
                rbsf_pkg::REG_RECT_TOP:        r_cfg.rect_top        <= pwdata[12:0];
                rbsf_pkg::REG_RECT_RIGHT:      r_cfg.rect_right      <= pwdata[12:0];
                rbsf_pkg::REG_RECT_BOTTOM:     r_cfg.rect_bottom     <= pwdata[12:0];
                rbsf_pkg::REG_FILL_MODE:       r_cfg.fill_mode       <= pwdata[2:0];
                rbsf_pkg::REG_FILL_COLOR:      r_cfg.fill_color      <= pwdata;
                rbsf_pkg::REG_BORDER_SIZE:     r_cfg.border_size     <= pwdata[12:0];
                rbsf_pkg::REG_SHADOW_STRENGTH: r_cfg.shadow_strength <= pwdata[7:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Read back: zero-extend the addressed register.
    always_comb begin
        case (cfg_idx)
            rbsf_pkg::REG_RECT_LEFT:       prdata = {19'd0, r_cfg.rect_left};
            rbsf_pkg::REG_RECT_TOP:        prdata = {19'd0, r_cfg.rect_top};
            rbsf_pkg::REG_RECT_RIGHT:      prdata = {19'd0, r_cfg.rect_right};
            rbsf_pkg::REG_RECT_BOTTOM:     prdata = {19'd0, r_cfg.rect_bottom};
            rbsf_pkg::REG_FILL_MODE:       prdata = {29'd0, r_cfg.fill_mode};
            rbsf_pkg::REG_FILL_COLOR:      prdata = r_cfg.fill_color;
            rbsf_pkg::REG_BORDER_SIZE:     prdata = {19'd0, r_cfg.border_size};
            rbsf_pkg::REG_SHADOW_STRENGTH: prdata = {24'd0, r_cfg.shadow_strength};
            default:                       prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- pipeline
    // Advance the input stage whenever the output register is empty or drains.
    assign s1_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_s1_valid  = o_in_ready ? i_in_valid : r_s1_valid;
        n_out_valid = s1_advance ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_data <= core_out;
        end
    end

    rbsf_pixel_core u_core (
        .i_cfg (r_cfg),
        .i_pix (r_s1_data),
        .o_pix (core_out)
    );

    // ---------------------------------------------------------------- checks
    // A pixel leaving the input stage shows up on the output next cycle.
    a_advance_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_advance) |=> o_out_valid)
        else $error("input stage advanced but no result appeared");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register empty");

    // Unused modes never mark a pixel as written.
    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_advance && (r_cfg.fill_mode > rbsf_pkg::MODE_SET_RGB))
        |=> !o_out_data.modified)
        else $error("pixel modified under an unused mode");

endmodule
